[rtl/core/u8d_pkg.sv]
// Shared types and constants of the UTF-8 stream decoder.
package u8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 32;
  localparam int unsigned OwedW  = 3;
  localparam int unsigned ContW  = 6;
  localparam int unsigned BufCntW = 2;

  localparam logic [ByteW-1:0] LeadBit  = 8'h80;
  localparam logic [ByteW-1:0] ContMask = 8'h3f;
  localparam logic [ByteW-1:0] TopMark  = 8'h20;

  typedef logic [ByteW-1:0] data_byte_t;
  typedef logic [CpW-1:0]   cp_t;
  typedef logic [OwedW-1:0] owed_t;
  typedef logic [BufCntW-1:0] buf_cnt_t;

  typedef struct packed {
    cp_t  code_point;
    logic run_last;
  } res_t;

  typedef struct packed {
    owed_t owed;
    cp_t   value;
  } lead_t;

  function automatic lead_t lead_decode(input data_byte_t b);
    lead_t r;
    r.value = '0;
    if ((b & TopMark) == '0) begin
      r.owed  = owed_t'(1);
      r.value = cp_t'(b[4:0]);
    end else if (!b[4]) begin
      r.owed  = owed_t'(2);
      r.value = cp_t'(b[3:0]);
    end else if (!b[3]) begin
      r.owed  = owed_t'(3);
      r.value = cp_t'(b[2:0]);
    end else if (!b[2]) begin
      r.owed  = owed_t'(4);
      r.value = cp_t'(b[1:0]);
    end else if (!b[1]) begin
      r.owed  = owed_t'(5);
      r.value = cp_t'(b[0]);
    end else if (!b[0]) begin
      r.owed  = owed_t'(6);
      r.value = '0;
    end else begin
      r.owed  = owed_t'(7);
      r.value = cp_t'(b);
    end
    return r;
  endfunction

endpackage

[rtl/core/u8d_in_if.sv]
// Byte channel of the UTF-8 stream decoder.
interface u8d_in_if;
  logic                valid;
  logic                ready;
  u8d_pkg::data_byte_t data_byte;
  logic                end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

[rtl/core/u8d_out_if.sv]
// Code point channel of the UTF-8 stream decoder.
interface u8d_out_if;
  logic         valid;
  logic         ready;
  u8d_pkg::cp_t code_point;
  logic         run_last;

  modport source (output valid, output code_point, output run_last, input ready);
  modport sink   (input valid, input code_point, input run_last, output ready);
endinterface

[rtl/core/utf8_stream_decoder.sv]
// UTF-8 stream decoder (lax 8-byte scheme): byte words in, code point words out.
//
// in_i carries one byte per word with an end-of-string mark; out_o carries
// decoded code points, each with run_last set on the final word caused by
// an input byte. A broken sequence gives two output words (0, then the
// plain byte); a truncated one at end of string gives a single 0.
// A byte accepted on in_i is held in the input register and decoded from
// there; its first code point is then written into the output buffer,
// which drives out_o.
// Throughput: one byte per cycle while the receiver keeps taking words. The
// decoded words go into a two-entry output buffer; a byte that yields two
// words needs both slots free, so a broken sequence can hold off the next byte.
// Reset empties the input register and the output buffer and clears the decode
// state (no sequence pending, partial value zero).
// When the receiver stalls, the buffer fills, the input register holds its
// byte and in_i.ready drops once that byte has no room; no word is lost.
module utf8_stream_decoder import u8d_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  u8d_in_if.sink    in_i,
  u8d_out_if.source out_o
);

  logic       s1_valid_q;
  data_byte_t s1_byte_q;
  logic       s1_eos_q;
  logic       s1_fire;

  cp_t   part_q, part_d;
  owed_t owed_q, owed_d;

  res_t     buf_q [2];
  res_t     buf_d [2];
  buf_cnt_t cnt_q, cnt_d, cnt_left, room;
  logic     pop;

  buf_cnt_t n_push;
  res_t     res0, res1;
  lead_t    lead;
  cp_t      acc;
  owed_t    owed_dec;

  // decode
  always_comb begin
    lead     = lead_decode(s1_byte_q);
    acc      = {part_q[CpW-ContW-1:0], s1_byte_q[ContW-1:0] & ContMask[ContW-1:0]};
    owed_dec = owed_q - owed_t'(1);
    n_push   = '0;
    res0     = '{code_point: '0, run_last: 1'b1};
    res1     = '{code_point: cp_t'(s1_byte_q), run_last: 1'b1};
    part_d   = part_q;
    owed_d   = owed_q;
    if (owed_q == '0) begin
      if ((s1_byte_q & LeadBit) == '0) begin
        n_push          = buf_cnt_t'(1);
        res0.code_point = cp_t'(s1_byte_q);
      end else if (s1_eos_q) begin
        n_push = buf_cnt_t'(1);
        part_d = '0;
        owed_d = '0;
      end else begin
        part_d = lead.value;
        owed_d = lead.owed;
      end
    end else if ((s1_byte_q & LeadBit) == '0) begin
      n_push        = buf_cnt_t'(2);
      res0.run_last = 1'b0;
      part_d        = '0;
      owed_d        = '0;
    end else if (owed_dec == '0) begin
      n_push          = buf_cnt_t'(1);
      res0.code_point = acc;
      part_d          = '0;
      owed_d          = '0;
    end else if (s1_eos_q) begin
      n_push = buf_cnt_t'(1);
      part_d = '0;
      owed_d = '0;
    end else begin
      part_d = acc;
      owed_d = owed_dec;
    end
  end

  assign pop      = (cnt_q != '0) && out_o.ready;
  assign cnt_left = cnt_q - buf_cnt_t'(pop);
  assign room     = buf_cnt_t'(2) - cnt_left;
  assign s1_fire  = s1_valid_q && (n_push <= room);

  assign in_i.ready = !s1_valid_q || s1_fire;

  // output buffer: pop head, then append
  always_comb begin
    buf_d[0] = buf_q[0];
    buf_d[1] = buf_q[1];
    if (pop) begin
      buf_d[0] = buf_q[1];
    end
    cnt_d = cnt_left;
    if (s1_fire && (n_push != '0)) begin
      cnt_d = cnt_left + n_push;
      if (cnt_left == '0) begin
        buf_d[0] = res0;
        buf_d[1] = res1;
      end else begin
        buf_d[1] = res0;
      end
    end
  end

  assign out_o.valid      = (cnt_q != '0);
  assign out_o.code_point = buf_q[0].code_point;
  assign out_o.run_last   = buf_q[0].run_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      cnt_q      <= '0;
      part_q     <= '0;
      owed_q     <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      cnt_q <= cnt_d;
      if (s1_fire) begin
        part_q <= part_d;
        owed_q <= owed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.data_byte;
      s1_eos_q  <= in_i.end_of_string;
    end
    buf_q[0] <= buf_d[0];
    buf_q[1] <= buf_d[1];
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= buf_cnt_t'(2))
    else $error("output buffer count out of range");

  a_split_needs_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && n_push == buf_cnt_t'(2)) |-> owed_q != '0)
    else $error("two words pushed without a pending sequence");

  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_eos_q) |=> owed_q == '0)
    else $error("sequence still pending after end of string");

  a_not_last_has_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.run_last) |-> cnt_q == buf_cnt_t'(2))
    else $error("non-final word without its follower buffered");
`endif

endmodule

[sim/tb.sv]
// Testbench of utf8_stream_decoder: fixed and random byte streams vs a built-in decoder.
`timescale 1ns / 1ps

module tb;
  import u8d_pkg::*;

  localparam int unsigned NumRandom = 1100;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 90;

  typedef struct packed {
    data_byte_t b;
    logic       eos;
  } byte_word_t;

  logic clk;
  logic rst_n;

  u8d_in_if  in_if ();
  u8d_out_if out_if ();

  utf8_stream_decoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  byte_word_t pend_q[$];
  res_t       cp_exp_q[$];

  cp_t   dec_val;
  owed_t dec_owed;

  int n_bytes;
  int n_cps;
  int n_complete;
  int n_broken;
  int n_trunc;
  int n_err;
  int cyc;
  int hold_left;
  logic hold_done;
  logic calm;

  assign calm = (n_bytes >= 300) && (n_bytes < 500);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (n_err < 30) $display("MISMATCH @%0d: %s", cyc, msg);
    n_err++;
  endtask

  task automatic decode_byte(input data_byte_t b, input logic eos);
    owed_t k;
    int    z;
    cp_t   v;
    if (dec_owed == '0) begin
      if (!b[7]) begin
        cp_exp_q.push_back('{code_point: cp_t'(b), run_last: 1'b1});
      end else begin
        k = owed_t'(1);
        z = 5;
        while (z >= 0 && b[z]) begin
          k++;
          z--;
        end
        if (z < 0) v = cp_t'(b);
        else v = cp_t'(b) & ((cp_t'(1) << z) - cp_t'(1));
        if (eos) begin
          cp_exp_q.push_back('{code_point: '0, run_last: 1'b1});
          dec_val  = '0;
          dec_owed = '0;
          n_trunc++;
        end else begin
          dec_val  = v;
          dec_owed = k;
        end
      end
    end else if (!b[7]) begin
      cp_exp_q.push_back('{code_point: '0, run_last: 1'b0});
      cp_exp_q.push_back('{code_point: cp_t'(b), run_last: 1'b1});
      dec_val  = '0;
      dec_owed = '0;
      n_broken++;
    end else begin
      dec_val  = {dec_val[CpW-7:0], b[5:0]};
      dec_owed = dec_owed - owed_t'(1);
      if (dec_owed == '0) begin
        cp_exp_q.push_back('{code_point: dec_val, run_last: 1'b1});
        dec_val = '0;
        n_complete++;
      end else if (eos) begin
        cp_exp_q.push_back('{code_point: '0, run_last: 1'b1});
        dec_val  = '0;
        dec_owed = '0;
        n_trunc++;
      end
    end
  endtask

  task automatic push_word(input data_byte_t b, input logic eos);
    pend_q.push_back('{b: b, eos: eos});
  endtask

  function automatic data_byte_t make_lead(input int k);
    data_byte_t b;
    int zp;
    if (k >= 7) return 8'hff;
    b = 8'h80 | data_byte_t'($urandom_range(0, 127));
    zp = 6 - k;
    for (int i = 5; i > zp; i--) b[i] = 1'b1;
    b[zp] = 1'b0;
    return b;
  endfunction

  always @(posedge clk or negedge rst_n) begin : drv
    byte_word_t w;
    if (!rst_n) begin
      in_if.valid         <= 1'b0;
      in_if.data_byte     <= '0;
      in_if.end_of_string <= 1'b0;
      n_bytes             <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        decode_byte(in_if.data_byte, in_if.end_of_string);
        n_bytes <= n_bytes + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pend_q.size() != 0 && (calm || $urandom_range(0, 99) >= 13)) begin
          w = pend_q.pop_front();
          in_if.valid         <= 1'b1;
          in_if.data_byte     <= w.b;
          in_if.end_of_string <= w.eos;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_bytes >= 700) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk or negedge rst_n) begin : mon
    res_t e;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_cps++;
        if (cp_exp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected code point %h", out_if.code_point));
        end else begin
          e = cp_exp_q.pop_front();
          if (out_if.code_point !== e.code_point)
            report_mismatch($sformatf("code_point %h, want %h",
                                      out_if.code_point, e.code_point));
          if (out_if.run_last !== e.run_last)
            report_mismatch($sformatf("run_last %b, want %b (code_point %h)",
                                      out_if.run_last, e.run_last, e.code_point));
        end
      end
      out_if.ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 13);
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d code points still due", cyc, cp_exp_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int kind;
    int k;
    int j;
    int base;
    cyc        = 0;
    n_cps      = 0;
    n_complete = 0;
    n_broken   = 0;
    n_trunc    = 0;
    n_err      = 0;
    dec_val    = '0;
    dec_owed   = '0;
    rst_n      = 1'b0;

    push_word(8'h00, 1'b0);
    push_word(8'h7f, 1'b1);
    push_word(8'hc3, 1'b0);
    push_word(8'ha9, 1'b0);
    push_word(8'he2, 1'b0);
    push_word(8'h82, 1'b0);
    push_word(8'hac, 1'b1);
    push_word(8'hff, 1'b0);
    for (int i = 0; i < 7; i++) push_word(8'hbf, 1'b0);
    push_word(8'he2, 1'b1);
    push_word(8'hf0, 1'b0);
    push_word(8'h9f, 1'b0);
    push_word(8'h41, 1'b0);
    push_word(8'hf8, 1'b0);
    push_word(8'h88, 1'b1);
    push_word(8'h80, 1'b0);
    push_word(8'h80, 1'b0);
    push_word(8'hfe, 1'b0);
    push_word(8'h00, 1'b0);

    base = pend_q.size();
    while (pend_q.size() < base + NumRandom) begin
      kind = $urandom_range(0, 99);
      k    = $urandom_range(1, 7);
      if (kind < 55) begin
        push_word(make_lead(k), 1'b0);
        for (int i = 0; i < k; i++)
          push_word(8'h80 | data_byte_t'($urandom_range(0, 127)), 1'b0);
        if ($urandom_range(0, 3) == 0) pend_q[pend_q.size()-1].eos = 1'b1;
      end else if (kind < 70) begin
        j = $urandom_range(1, 4);
        for (int i = 0; i < j; i++)
          push_word(data_byte_t'($urandom_range(0, 127)), $urandom_range(0, 7) == 0);
      end else if (kind < 82) begin
        j = $urandom_range(0, k - 1);
        push_word(make_lead(k), 1'b0);
        for (int i = 0; i < j; i++)
          push_word(8'h80 | data_byte_t'($urandom_range(0, 127)), 1'b0);
        push_word(data_byte_t'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      end else if (kind < 92) begin
        j = $urandom_range(0, k - 1);
        push_word(make_lead(k), 1'b0);
        for (int i = 0; i < j; i++)
          push_word(8'h80 | data_byte_t'($urandom_range(0, 127)), 1'b0);
        pend_q[pend_q.size()-1].eos = 1'b1;
      end else begin
        push_word(data_byte_t'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || in_if.valid) @(posedge clk);
    while (cp_exp_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Fed %0d bytes and checked %0d code points in %0d cycles.", n_bytes, n_cps, cyc);
    $display("Sequences: %0d complete, %0d broken by a plain byte, %0d cut off at end of string.",
             n_complete, n_broken, n_trunc);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", n_err);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/u8d_pkg.sv
rtl/core/u8d_in_if.sv
rtl/core/u8d_out_if.sv
rtl/core/utf8_stream_decoder.sv
sim/tb.sv
